FILE: src/affine_global_alignment_score_assert.svh
// Assertion macros used by the alignment score checker.
`ifndef AFFINE_GLOBAL_ALIGNMENT_SCORE_ASSERT_SVH
`define AFFINE_GLOBAL_ALIGNMENT_SCORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define AGAS_AST_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define AGAS_AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/agas_pkg.sv
// Shared types and constants of the affine-gap global alignment score block.
package agas_pkg;

  // Field widths fixed by the interface
  localparam int RES_W   = 8;
  localparam int AWARD_W = 7;
  localparam int COST_W  = 6;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 7;

  // Item kinds carried in in_tuser[1:0]
  localparam logic [1:0] KIND_A   = 2'd0;
  localparam logic [1:0] KIND_B   = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_MATCH    = 2'd0;
  localparam logic [CFG_AW-1:0] REG_MISMATCH = 2'd1;
  localparam logic [CFG_AW-1:0] REG_OPEN     = 2'd2;
  localparam logic [CFG_AW-1:0] REG_EXTEND   = 2'd3;

  // Cost inputs of the cell unit
  typedef struct packed {
    logic signed [AWARD_W-1:0] subst;
    logic [COST_W-1:0]         open_cost;
    logic [COST_W-1:0]         ext_cost;
  } cell_cost_t;

endpackage

FILE: src/agas_ram.sv
// Simple dual-port memory: one write port, one registered read port.
module agas_ram
  #(
    parameter int DW    = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
  )
  (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
  );

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/agas_cell.sv
// Saturating Gotoh cell unit: computes one row of the new score column.
module agas_cell import agas_pkg::*;
  #(
    parameter int SB = 20
  )
  (
    input  cell_cost_t           costs_i,
    input  logic signed [SB-1:0] diag_i,   // old best score of the row above
    input  logic signed [SB-1:0] m_up_i,   // new match score of the row above
    input  logic signed [SB-1:0] b_up_i,   // new gap-in-B score of the row above
    input  logic signed [SB-1:0] m_old_i,  // old scores of this row
    input  logic signed [SB-1:0] b_old_i,
    input  logic signed [SB-1:0] a_old_i,
    input  logic signed [SB-1:0] g_i,      // all-gap score for this row
    output logic signed [SB-1:0] nm_o,
    output logic signed [SB-1:0] ni_o,
    output logic signed [SB-1:0] nj_o,
    output logic signed [SB-1:0] old_h_o,
    output logic signed [SB-1:0] new_h_o,
    output logic signed [SB-1:0] g_next_o
  );

  localparam logic signed [SB-1:0] SC_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0] SC_MAX = {1'b0, {(SB-1){1'b1}}};

  // minus infinity absorbs; other sums clamp to the field
  function automatic logic signed [SB-1:0] sat_add(input logic signed [SB-1:0] a,
                                                   input logic signed [7:0]    d);
    logic signed [SB:0] s;
    s = (SB+1)'(a) + (SB+1)'(d);
    if (a == SC_MIN) begin
      return SC_MIN;
    end else if (s < (SB+1)'(SC_MIN)) begin
      return SC_MIN;
    end else if (s > (SB+1)'(SC_MAX)) begin
      return SC_MAX;
    end else begin
      return s[SB-1:0];
    end
  endfunction

  function automatic logic signed [SB-1:0] max2(input logic signed [SB-1:0] a,
                                                input logic signed [SB-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic signed [7:0] n_open;
  logic signed [7:0] n_ext;
  logic signed [7:0] subst;

  assign n_open = 8'sd0 - $signed({2'b00, costs_i.open_cost});
  assign n_ext  = 8'sd0 - $signed({2'b00, costs_i.ext_cost});
  assign subst  = 8'(costs_i.subst);

  // three state updates
  assign nm_o = sat_add(diag_i, subst);
  assign ni_o = max2(sat_add(m_up_i, n_open), sat_add(b_up_i, n_ext));
  assign nj_o = max2(sat_add(m_old_i, n_open), sat_add(a_old_i, n_ext));

  // best scores of the old and new cell
  assign old_h_o = max2(m_old_i, max2(b_old_i, a_old_i));
  assign new_h_o = max2(nm_o, max2(ni_o, nj_o));

  // all-gap score of the next row for a freshly started column
  assign g_next_o = sat_add(g_i, n_ext);

endmodule

FILE: src/affine_global_alignment_score.sv
// Top level of the affine-gap global alignment score block.
// Sequence A residues (kind 0) are stored one per word without leaving idle. Each
// B residue (kind 1) rebuilds one score column with a single saturating cell
// unit that walks the stored A positions one row per cycle through the column
// memory, so a B word occupies the block through S_MUL, S_GAP and S_RUN, plus
// S_DONE to hand over the score when the word carries tlast. An end word (kind 2)
// goes through S_MUL, S_GAP and S_DONE. in_tready is low while a word is being
// worked on. No clearing pass follows reset: stores are read only where written.
module affine_global_alignment_score import agas_pkg::*;
  #(
    parameter int MAX_LEN    = 64,
    parameter int SCORE_BITS = 20
  )
  (
    input  logic                                clk,
    input  logic                                rst_n,
    // input words
    input  logic                                in_tvalid,
    output logic                                in_tready,
    input  logic [7:0]                          in_tdata,  // residue
    input  logic [2:0]                          in_tuser,  // kind[1:0], first
    input  logic                                in_tlast,  // last
    // result words
    output logic                                out_tvalid,
    input  logic                                out_tready,
    output logic [((SCORE_BITS+7)/8)*8-1:0]     out_tdata, // score, zero padded
    output logic [1:0]                          out_tuser, // both_empty, too_long
    // configuration
    input  logic                                cfg_we,
    input  logic [CFG_AW-1:0]                   cfg_addr,
    input  logic [CFG_DW-1:0]                   cfg_wdata
  );

  localparam int SB = SCORE_BITS;
  localparam int OW = ((SCORE_BITS+7)/8)*8;
  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN+1);
  localparam int PW = COST_W + AW;
  localparam int GW = ((PW > SB) ? PW : SB) + 2;

  localparam logic signed [SB-1:0] SC_MIN = {1'b1, {(SB-1){1'b0}}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_GAP  = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // control registers
  logic [2:0]                state_r, state_nxt;
  logic [LW-1:0]             a_len_r, a_len_nxt;
  logic [LW-1:0]             b_cnt_r, b_cnt_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [AWARD_W-1:0] match_r, match_nxt;
  logic signed [AWARD_W-1:0] mism_r, mism_nxt;
  logic [COST_W-1:0]         open_r, open_nxt;
  logic [COST_W-1:0]         ext_r, ext_nxt;

  // payload registers
  logic                      op_end_r, op_end_nxt;
  logic                      empty_r, empty_nxt;
  logic                      fresh_r, fresh_nxt;
  logic                      last_req_r, last_req_nxt;
  logic [AW-1:0]             km1_r, km1_nxt;
  logic [RES_W-1:0]          res_r, res_nxt;
  logic [PW-1:0]             prod_r, prod_nxt;
  logic [AW-1:0]             wr_idx_r, wr_idx_nxt;
  logic signed [SB-1:0]      gap0_r, gap0_nxt;
  logic signed [SB-1:0]      last_h_r, last_h_nxt;
  logic signed [SB-1:0]      diag_r, diag_nxt;
  logic signed [SB-1:0]      m_up_r, m_up_nxt;
  logic signed [SB-1:0]      b_up_r, b_up_nxt;
  logic signed [SB-1:0]      g_r, g_nxt;
  logic [SB-1:0]             out_score_r, out_score_nxt;
  logic                      out_empty_r, out_empty_nxt;
  logic                      out_ovf_r, out_ovf_nxt;

  // memory ports
  logic                      seq_we;
  logic [AW-1:0]             seq_waddr;
  logic [RES_W-1:0]          seq_rdata;
  logic                      col_we;
  logic [AW-1:0]             col_raddr;
  logic [3*SB-1:0]           col_wdata;
  logic [3*SB-1:0]           col_rdata;

  // cell unit signals
  cell_cost_t                costs;
  logic signed [SB-1:0]      m_old, b_old, a_old;
  logic signed [SB-1:0]      nm, ni, nj, old_h, new_h, g_next;

  // scratch
  logic                      acc;
  logic                      first;
  logic                      fresh;
  logic [LW-1:0]             len_eff;
  logic [LW-1:0]             b_eff;
  logic signed [GW-1:0]      gap_wide;
  logic signed [SB-1:0]      gapv;

  assign acc   = in_tvalid && in_tready;
  assign first = in_tuser[2];

  // all-gap score from the registered product
  assign gap_wide = $signed(GW'(0)) - $signed(GW'(open_r)) - $signed(GW'(prod_r));
  assign gapv     = (gap_wide < GW'(SC_MIN)) ? SC_MIN : gap_wide[SB-1:0];

  // stored column, or the starting column when a new B begins
  assign m_old = fresh_r ? SC_MIN : $signed(col_rdata[SB-1:0]);
  assign b_old = fresh_r ? g_r    : $signed(col_rdata[2*SB-1:SB]);
  assign a_old = fresh_r ? SC_MIN : $signed(col_rdata[3*SB-1:2*SB]);

  assign costs.subst     = (seq_rdata == res_r) ? match_r : mism_r;
  assign costs.open_cost = open_r;
  assign costs.ext_cost  = ext_r;

  assign col_raddr = (state_r == S_GAP) ? '0 : AW'(wr_idx_r + 1'b1);
  assign col_wdata = {nj, ni, nm};

  agas_ram #(.DW(RES_W), .DEPTH(MAX_LEN)) u_seq_ram (
    .clk   (clk),
    .we    (seq_we),
    .waddr (seq_waddr),
    .wdata (in_tdata),
    .raddr (col_raddr),
    .rdata (seq_rdata)
  );

  agas_ram #(.DW(3*SB), .DEPTH(MAX_LEN)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (wr_idx_r),
    .wdata (col_wdata),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  agas_cell #(.SB(SB)) u_cell (
    .costs_i  (costs),
    .diag_i   (diag_r),
    .m_up_i   (m_up_r),
    .b_up_i   (b_up_r),
    .m_old_i  (m_old),
    .b_old_i  (b_old),
    .a_old_i  (a_old),
    .g_i      (g_r),
    .nm_o     (nm),
    .ni_o     (ni),
    .nj_o     (nj),
    .old_h_o  (old_h),
    .new_h_o  (new_h),
    .g_next_o (g_next)
  );

  // sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    a_len_nxt     = a_len_r;
    b_cnt_nxt     = b_cnt_r;
    ovf_nxt       = ovf_r;
    match_nxt     = match_r;
    mism_nxt      = mism_r;
    open_nxt      = open_r;
    ext_nxt       = ext_r;
    op_end_nxt    = op_end_r;
    empty_nxt     = empty_r;
    fresh_nxt     = fresh_r;
    last_req_nxt  = last_req_r;
    km1_nxt       = km1_r;
    res_nxt       = res_r;
    prod_nxt      = prod_r;
    wr_idx_nxt    = wr_idx_r;
    gap0_nxt      = gap0_r;
    last_h_nxt    = last_h_r;
    diag_nxt      = diag_r;
    m_up_nxt      = m_up_r;
    b_up_nxt      = b_up_r;
    g_nxt         = g_r;
    out_score_nxt = out_score_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    seq_we        = 1'b0;
    seq_waddr     = '0;
    col_we        = 1'b0;
    fresh         = first || (b_cnt_r == '0);
    len_eff       = first ? '0 : a_len_r;
    b_eff         = fresh ? '0 : b_cnt_r;

    // configuration writes
    if (cfg_we) begin
      case (cfg_addr)
        REG_MATCH:    match_nxt = $signed(cfg_wdata[AWARD_W-1:0]);
        REG_MISMATCH: mism_nxt  = $signed(cfg_wdata[AWARD_W-1:0]);
        REG_OPEN:     open_nxt  = cfg_wdata[COST_W-1:0];
        REG_EXTEND:   ext_nxt   = cfg_wdata[COST_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_tuser[1:0])
            KIND_A: begin
              b_cnt_nxt = '0;
              if (first) begin
                ovf_nxt = 1'b0;
              end
              if (len_eff >= LW'(MAX_LEN)) begin
                ovf_nxt = 1'b1;
              end else begin
                seq_we    = 1'b1;
                seq_waddr = len_eff[AW-1:0];
                a_len_nxt = len_eff + 1'b1;
              end
            end
            KIND_B: begin
              op_end_nxt = 1'b0;
              empty_nxt  = 1'b0;
              if (b_eff >= LW'(MAX_LEN)) begin
                // B too long: word dropped, score of the stored part
                ovf_nxt = 1'b1;
                if (in_tlast) begin
                  b_cnt_nxt = '0;
                  state_nxt = S_DONE;
                end
              end else begin
                b_cnt_nxt    = in_tlast ? '0 : b_eff + 1'b1;
                fresh_nxt    = fresh;
                km1_nxt      = b_eff[AW-1:0];
                res_nxt      = in_tdata;
                last_req_nxt = in_tlast;
                state_nxt    = S_MUL;
              end
            end
            KIND_END: begin
              b_cnt_nxt  = '0;
              op_end_nxt = 1'b1;
              empty_nxt  = (a_len_r == '0);
              km1_nxt    = AW'(a_len_r - 1'b1);
              state_nxt  = S_MUL;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        prod_nxt  = PW'(ext_r) * PW'(km1_r);
        state_nxt = S_GAP;
      end
      S_GAP: begin
        if (op_end_r) begin
          last_h_nxt = empty_r ? SC_MIN : gapv;
          state_nxt  = S_DONE;
        end else begin
          // row 0 of the new column; first row read is issued now
          diag_nxt   = fresh_r ? '0 : gap0_r;
          gap0_nxt   = gapv;
          m_up_nxt   = SC_MIN;
          b_up_nxt   = SC_MIN;
          g_nxt      = SB'(0) - SB'(open_r);
          wr_idx_nxt = '0;
          if (a_len_r == '0) begin
            last_h_nxt = gapv;
            state_nxt  = last_req_r ? S_DONE : S_IDLE;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        // one row per cycle through the cell unit
        col_we   = 1'b1;
        diag_nxt = old_h;
        m_up_nxt = nm;
        b_up_nxt = ni;
        g_nxt    = g_next;
        if ((LW'(wr_idx_r) + 1'b1) == a_len_r) begin
          last_h_nxt = new_h;
          state_nxt  = last_req_r ? S_DONE : S_IDLE;
        end else begin
          wr_idx_nxt = wr_idx_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_score_nxt = last_h_r;
          out_empty_nxt = empty_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      a_len_r     <= '0;
      b_cnt_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      match_r     <= 7'sd1;
      mism_r      <= -7'sd1;
      open_r      <= 6'd7;
      ext_r       <= 6'd3;
    end else begin
      state_r     <= state_nxt;
      a_len_r     <= a_len_nxt;
      b_cnt_r     <= b_cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      match_r     <= match_nxt;
      mism_r      <= mism_nxt;
      open_r      <= open_nxt;
      ext_r       <= ext_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    op_end_r    <= op_end_nxt;
    empty_r     <= empty_nxt;
    fresh_r     <= fresh_nxt;
    last_req_r  <= last_req_nxt;
    km1_r       <= km1_nxt;
    res_r       <= res_nxt;
    prod_r      <= prod_nxt;
    wr_idx_r    <= wr_idx_nxt;
    gap0_r      <= gap0_nxt;
    last_h_r    <= last_h_nxt;
    diag_r      <= diag_nxt;
    m_up_r      <= m_up_nxt;
    b_up_r      <= b_up_nxt;
    g_r         <= g_nxt;
    out_score_r <= out_score_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OW'(out_score_r);
  assign out_tuser  = {out_ovf_r, out_empty_r};

endmodule

FILE: src/agas_chk.sv
// Port-level checker for the alignment score block, with its bind.
`include "affine_global_alignment_score_assert.svh"

module agas_chk import agas_pkg::*;
  #(
    parameter int SCORE_BITS = 20
  )
  (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_tvalid,
    input logic                            in_tready,
    input logic [2:0]                      in_tuser,
    input logic                            out_tvalid,
    input logic                            out_tready,
    input logic [((SCORE_BITS+7)/8)*8-1:0] out_tdata,
    input logic [1:0]                      out_tuser
  );

  localparam logic [SCORE_BITS-1:0] SC_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

  // a stalled result word holds
  `AGAS_AST_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result word changed while stalled")

  // both sequences empty always reports the minimum score
  `AGAS_AST_SAME(a_empty_min, out_tvalid && out_tuser[0], out_tdata[SCORE_BITS-1:0] == SC_MIN, "empty result without minimum score")

  // an A residue leaves the block ready again in the next cycle
  `AGAS_AST_NEXT(a_kind_a_fast, in_tvalid && in_tready && in_tuser[1:0] == KIND_A, in_tready, "not ready after A residue")

  // an end word keeps the block busy for the gap score
  `AGAS_AST_NEXT(a_end_busy, in_tvalid && in_tready && in_tuser[1:0] == KIND_END, !in_tready, "ready right after end word")

endmodule

bind affine_global_alignment_score agas_chk #(.SCORE_BITS(SCORE_BITS)) u_agas_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
